// ===== src/aouc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the rounded fixed-point product for the alpha compositor.
// No dependencies.
package aouc_pkg;

    localparam int CH_W = 16;

    typedef logic [CH_W-1:0] t_chan;
    typedef logic [3:0][CH_W-1:0] t_pix;
    typedef logic [1:0] t_byp;

    localparam t_chan FX_ONE = t_chan'(1) << (CH_W - 1);
    localparam t_chan FX_MAX = '1;
    localparam logic [2*CH_W-1:0] FX_HALF = (2*CH_W)'(1) << (CH_W - 2);

    localparam t_byp BYP_NONE = 2'd0;
    localparam t_byp BYP_BASE = 2'd1;
    localparam t_byp BYP_TOP  = 2'd2;

    localparam logic MODE_OVER  = 1'b0;
    localparam logic MODE_UNDER = 1'b1;

    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_FACTOR = 1'b1;

    // Rounds half up, then saturates at the channel maximum.
    function automatic t_chan fx_mul(input t_chan a, input t_chan b);
        logic [2*CH_W-1:0] prod;
        logic [CH_W:0]     q;
        prod = {{CH_W{1'b0}}, a} * {{CH_W{1'b0}}, b};
        prod = prod + FX_HALF;
        q = prod[2*CH_W-1:CH_W-1];
        return q[CH_W] ? FX_MAX : q[CH_W-1:0];
    endfunction

endpackage

// ===== src/alpha_over_under_composite_unit.sv =====
`timescale 1ns / 1ps
// Top level of the premultiplied RGBA over/under compositor with a fade factor.
// Depends on aouc_pkg for widths, codes and the fixed-point product.
//
// Usage: a pixel pair is presented on the i_top_* and i_base_* ports with
// i_end_of_image and is taken on a rising edge where start is high and busy is
// low. The block never raises busy, so one pixel may be transferred every
// clock cycle. Each pixel yields exactly one result on the o_mix_* ports,
// shown for one cycle while o_valid is high; the receiver cannot stall it.
// The transfer edge loads the input register; a product stage, a weight stage,
// a second product stage and an output adder stage follow, each registered.
// The two chained multiplications set this depth.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data and
// should change only while no pixel is in flight. Index 0 selects the mode
// (0 over, 1 under), index 1 the fade factor with 1.0 at 2^15.
// Synchronous reset clears all valid bits, sets over mode and a factor of 1.0.
module alpha_over_under_composite_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [aouc_pkg::CH_W-1:0] i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [aouc_pkg::CH_W-1:0] i_top_red,
    input  logic [aouc_pkg::CH_W-1:0] i_top_green,
    input  logic [aouc_pkg::CH_W-1:0] i_top_blue,
    input  logic [aouc_pkg::CH_W-1:0] i_top_alpha,
    input  logic [aouc_pkg::CH_W-1:0] i_base_red,
    input  logic [aouc_pkg::CH_W-1:0] i_base_green,
    input  logic [aouc_pkg::CH_W-1:0] i_base_blue,
    input  logic [aouc_pkg::CH_W-1:0] i_base_alpha,
    input  logic                 i_end_of_image,
    output logic                 o_valid,
    output logic [aouc_pkg::CH_W-1:0] o_mix_red,
    output logic [aouc_pkg::CH_W-1:0] o_mix_green,
    output logic [aouc_pkg::CH_W-1:0] o_mix_blue,
    output logic [aouc_pkg::CH_W-1:0] o_mix_alpha,
    output logic                 o_end_of_image_out
);
    import aouc_pkg::*;

    logic  r_mode;
    t_chan r_factor;

    logic  r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e;

    t_pix  r_p1_a, r_p2_a;
    t_chan r_f_a;
    logic  r_mode_a, r_eoi_a;

    t_pix  r_p1_b, r_p2_b, r_t1_b;
    t_chan r_k_b;
    t_byp  r_byp_b;
    logic  r_mode_b, r_eoi_b;

    t_pix  r_p1_c, r_p2_c, r_t1_c;
    t_chan r_w_c;
    logic  r_neg_c;
    t_byp  r_byp_c;
    logic  r_mode_c, r_eoi_c;

    t_pix  r_p1_d, r_p2_d, r_t1_d, r_q_d;
    logic  r_neg_d;
    t_byp  r_byp_d;
    logic  r_mode_d, r_eoi_d;

    t_pix  r_res_e;
    logic  r_eoi_e;

    t_chan n_k_b;
    t_byp  n_byp_b;
    t_pix  n_t1_b;
    t_chan n_w_c;
    logic  n_neg_c;
    t_pix  n_q_d;
    t_pix  n_res_e;
    logic [CH_W:0] n_sum;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OVER;
            r_factor <= FX_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_FACTOR: r_factor <= i_cfg_data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else begin
            r_vld_a <= start & ~busy;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
            r_vld_e <= r_vld_d;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        r_p1_a   <= {i_top_alpha, i_top_blue, i_top_green, i_top_red};
        r_p2_a   <= {i_base_alpha, i_base_blue, i_base_green, i_base_red};
        r_f_a    <= r_factor;
        r_mode_a <= r_mode;
        r_eoi_a  <= i_end_of_image;
    end

    // First products and the pass-through decision.
    always_comb begin
        t_chan opnd;
        opnd = (r_mode_a == MODE_UNDER) ? t_chan'(FX_ONE - r_p2_a[3]) : r_p1_a[3];
        n_k_b = fx_mul(r_f_a, opnd);
        for (int i = 0; i < 4; i++) begin
            n_t1_b[i] = fx_mul(r_f_a, r_p1_a[i]);
        end
        if (r_mode_a == MODE_OVER) begin
            if (r_f_a == '0 || r_p1_a[3] == '0) begin
                n_byp_b = BYP_BASE;
            end else if (r_f_a == FX_ONE && r_p1_a[3] >= FX_ONE) begin
                n_byp_b = BYP_TOP;
            end else begin
                n_byp_b = BYP_NONE;
            end
        end else begin
            if (r_f_a == '0) begin
                n_byp_b = BYP_BASE;
            end else if (r_p2_a[3] == '0 && r_f_a >= FX_ONE) begin
                n_byp_b = BYP_TOP;
            end else if (r_p2_a[3] >= FX_ONE) begin
                n_byp_b = BYP_BASE;
            end else begin
                n_byp_b = BYP_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_b   <= r_p1_a;
        r_p2_b   <= r_p2_a;
        r_t1_b   <= n_t1_b;
        r_k_b    <= n_k_b;
        r_byp_b  <= n_byp_b;
        r_mode_b <= r_mode_a;
        r_eoi_b  <= r_eoi_a;
    end

    // Weight of the second product: over |1 - f*a1| plus a sign bit, under f*(1-a2).
    always_comb begin
        if (r_mode_b == MODE_OVER) begin
            n_neg_c = r_k_b > FX_ONE;
            n_w_c   = n_neg_c ? t_chan'(r_k_b - FX_ONE) : t_chan'(FX_ONE - r_k_b);
        end else begin
            n_neg_c = 1'b0;
            n_w_c   = r_k_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_c   <= r_p1_b;
        r_p2_c   <= r_p2_b;
        r_t1_c   <= r_t1_b;
        r_w_c    <= n_w_c;
        r_neg_c  <= n_neg_c;
        r_byp_c  <= r_byp_b;
        r_mode_c <= r_mode_b;
        r_eoi_c  <= r_eoi_b;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_q_d[i] = fx_mul(r_w_c, (r_mode_c == MODE_OVER) ? r_p2_c[i] : r_p1_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_d   <= r_p1_c;
        r_p2_d   <= r_p2_c;
        r_t1_d   <= r_t1_c;
        r_q_d    <= n_q_d;
        r_neg_d  <= r_neg_c;
        r_byp_d  <= r_byp_c;
        r_mode_d <= r_mode_c;
        r_eoi_d  <= r_eoi_c;
    end

    // Final sum or clamped difference, then the pass-through select.
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 4; i++) begin
            n_sum = {1'b0, (r_mode_d == MODE_OVER) ? r_t1_d[i] : r_p2_d[i]}
                  + {1'b0, r_q_d[i]};
            if (r_mode_d == MODE_OVER && r_neg_d) begin
                n_res_e[i] = (r_t1_d[i] > r_q_d[i]) ? t_chan'(r_t1_d[i] - r_q_d[i]) : '0;
            end else begin
                n_res_e[i] = n_sum[CH_W] ? FX_MAX : n_sum[CH_W-1:0];
            end
            unique case (r_byp_d)
                BYP_BASE: n_res_e[i] = r_p2_d[i];
                BYP_TOP:  n_res_e[i] = r_p1_d[i];
                default:  n_res_e[i] = n_res_e[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_e <= n_res_e;
        r_eoi_e <= r_eoi_d;
    end

    assign o_valid            = r_vld_e;
    assign o_mix_red          = r_res_e[0];
    assign o_mix_green        = r_res_e[1];
    assign o_mix_blue         = r_res_e[2];
    assign o_mix_alpha        = r_res_e[3];
    assign o_end_of_image_out = r_eoi_e;

endmodule

// ===== tb/sv/alpha_over_under_composite_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for alpha_over_under_composite_unit: it sends pixel pairs under a
// series of mode and fade settings and compares every result with its own over/under predictor.
// Depends on aouc_pkg and the alpha_over_under_composite_unit RTL.
module alpha_over_under_composite_unit_tb;
    import aouc_pkg::*;

    localparam longint unsigned Q_ONE  = 64'd1 << (CH_W - 1);
    localparam longint unsigned Q_HALF = 64'd1 << (CH_W - 2);
    localparam longint unsigned Q_MAX  = (64'd1 << CH_W) - 1;
    localparam int PHASES = 10;
    localparam int RANDOM_PER_PHASE = 85;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        t_pix top;
        t_pix base;
        logic eoi;
    } t_pixel_pair;

    typedef struct packed {
        t_pix mix;
        logic eoi;
    } t_mix;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    t_chan       cfg_data;
    logic        start;
    logic        busy;
    t_pixel_pair drv_pair;
    logic        o_valid;
    t_mix        got_mix;

    logic  cur_mode;
    t_chan cur_factor;
    int    send_gap_pct;
    int    err_count;
    logic  pix_taken;

    t_pixel_pair pending_q[$];
    t_mix        mix_expect_q[$];
    string       chan_name[4] = '{"red", "green", "blue", "alpha"};

    alpha_over_under_composite_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .start              (start),
        .busy               (busy),
        .i_top_red          (drv_pair.top[0]),
        .i_top_green        (drv_pair.top[1]),
        .i_top_blue         (drv_pair.top[2]),
        .i_top_alpha        (drv_pair.top[3]),
        .i_base_red         (drv_pair.base[0]),
        .i_base_green       (drv_pair.base[1]),
        .i_base_blue        (drv_pair.base[2]),
        .i_base_alpha       (drv_pair.base[3]),
        .i_end_of_image     (drv_pair.eoi),
        .o_valid            (o_valid),
        .o_mix_red          (got_mix.mix[0]),
        .o_mix_green        (got_mix.mix[1]),
        .o_mix_blue         (got_mix.mix[2]),
        .o_mix_alpha        (got_mix.mix[3]),
        .o_end_of_image_out (got_mix.eoi)
    );

    function automatic t_chan clamp_chan(longint unsigned v);
        return (v > Q_MAX) ? t_chan'(Q_MAX) : t_chan'(v);
    endfunction

    function automatic longint unsigned q15_mul(longint unsigned a, longint unsigned b);
        return 64'(clamp_chan((a * b + Q_HALF) >> (CH_W - 1)));
    endfunction

    function automatic t_mix predict_mix(logic mode, t_chan f, t_pixel_pair p);
        t_mix r;
        longint unsigned fv, fa, t1, t2, m;
        longint unsigned p1[4];
        longint unsigned p2[4];
        fv = 64'(f);
        for (int i = 0; i < 4; i++) begin
            p1[i] = 64'(p.top[i]);
            p2[i] = 64'(p.base[i]);
        end
        r.eoi = p.eoi;
        r.mix = p.base;
        if (mode == MODE_OVER) begin
            if (fv == 64'd0 || p1[3] == 64'd0) begin
                r.mix = p.base;
            end else if (fv == Q_ONE && p1[3] >= Q_ONE) begin
                r.mix = p.top;
            end else begin
                fa = q15_mul(fv, p1[3]);
                for (int i = 0; i < 4; i++) begin
                    t1 = q15_mul(fv, p1[i]);
                    if (fa <= Q_ONE) begin
                        r.mix[i] = clamp_chan(t1 + q15_mul(Q_ONE - fa, p2[i]));
                    end else begin
                        // The base weight is negative here, so the result floors at zero.
                        t2 = q15_mul(fa - Q_ONE, p2[i]);
                        r.mix[i] = (t1 > t2) ? t_chan'(t1 - t2) : t_chan'(0);
                    end
                end
            end
        end else begin
            if (fv == 64'd0) begin
                r.mix = p.base;
            end else if (p2[3] == 64'd0 && fv >= Q_ONE) begin
                r.mix = p.top;
            end else if (p2[3] >= Q_ONE) begin
                r.mix = p.base;
            end else begin
                m = q15_mul(fv, Q_ONE - p2[3]);
                for (int i = 0; i < 4; i++) begin
                    r.mix[i] = clamp_chan(q15_mul(m, p1[i]) + p2[i]);
                end
            end
        end
        return r;
    endfunction

    function automatic t_pix mk_pix(int r, int g, int b, int a);
        return {t_chan'(a), t_chan'(b), t_chan'(g), t_chan'(r)};
    endfunction

    function automatic t_chan rand_level();
        case ($urandom_range(7))
            0: return t_chan'(0);
            1: return t_chan'(Q_ONE);
            2: return t_chan'(Q_MAX);
            3: return t_chan'(Q_ONE - 1);
            4: return t_chan'(1);
            default: return t_chan'($urandom_range(32'(Q_MAX)));
        endcase
    endfunction

    // Colour channels mostly drawn no larger than alpha, with some arbitrary ones mixed in.
    function automatic t_pix rand_pix();
        t_pix p;
        p[3] = rand_level();
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(9) < 7) begin
                p[i] = t_chan'($urandom_range(32'(p[3])));
            end else begin
                p[i] = rand_level();
            end
        end
        return p;
    endfunction

    task automatic push_pair(t_pix top, t_pix base, logic eoi);
        pending_q.push_back('{top: top, base: base, eoi: eoi});
    endtask

    task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || start || mix_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic mode, t_chan factor);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MODE;
        cfg_data <= t_chan'(mode);
        cur_mode <= mode;
        @(negedge i_clk);
        cfg_idx    <= CFG_FACTOR;
        cfg_data   <= factor;
        cur_factor <= factor;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_directed(int phase);
        case (phase)
            0: begin
                push_pair(mk_pix(1000, 2000, 3000, 0), mk_pix(4000, 5000, 6000, 7000), 1'b0);
                push_pair(mk_pix(9000, 8000, 7000, 32768), mk_pix(100, 200, 300, 400), 1'b0);
                push_pair(mk_pix(65535, 0, 65535, 65535), mk_pix(1, 2, 3, 4), 1'b1);
                push_pair(mk_pix(0, 0, 0, 0), mk_pix(0, 0, 0, 0), 1'b0);
                push_pair(mk_pix(65535, 65535, 65535, 65535),
                          mk_pix(65535, 65535, 65535, 65535), 1'b1);
                push_pair(mk_pix(8000, 4000, 2000, 16384), mk_pix(20000, 30000, 1000, 32768),
                          1'b0);
                push_pair(mk_pix(1, 1, 1, 1), mk_pix(65535, 65535, 65535, 65535), 1'b0);
                push_pair(mk_pix(32767, 16384, 0, 32767), mk_pix(65535, 0, 32768, 65535), 1'b1);
            end
            1: begin
                push_pair(mk_pix(0, 10000, 65535, 32768), mk_pix(65535, 65535, 0, 65535), 1'b0);
                push_pair(mk_pix(10, 20, 30, 65535), mk_pix(30000, 40000, 50000, 60000), 1'b1);
                push_pair(mk_pix(500, 600, 700, 0), mk_pix(800, 900, 1000, 1100), 1'b0);
                push_pair(mk_pix(65535, 65535, 65535, 65535), mk_pix(0, 0, 0, 0), 1'b0);
            end
            3: begin
                push_pair(mk_pix(1234, 5678, 9012, 32768), mk_pix(50, 60, 70, 0), 1'b0);
                push_pair(mk_pix(1234, 5678, 9012, 32768), mk_pix(50, 60, 70, 32768), 1'b1);
                push_pair(mk_pix(65535, 65535, 65535, 65535),
                          mk_pix(65535, 65535, 65535, 16384), 1'b0);
                push_pair(mk_pix(20000, 10000, 5000, 30000), mk_pix(3000, 2000, 1000, 8000),
                          1'b0);
            end
            4: begin
                push_pair(mk_pix(40000, 30000, 20000, 50000), mk_pix(100, 200, 300, 0), 1'b1);
                push_pair(mk_pix(40000, 30000, 20000, 50000), mk_pix(100, 200, 300, 1), 1'b0);
            end
            5: begin
                push_pair(mk_pix(7, 8, 9, 10), mk_pix(11, 12, 13, 0), 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("alpha_over_under_composite_unit_tb: errors");
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || pix_taken) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                drv_pair <= pending_q.pop_front();
                start    <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_mix want;
        if (!i_rst_n) begin
            pix_taken <= 1'b0;
        end else begin
            pix_taken <= start && !busy;
            if (o_valid) begin
                if (mix_expect_q.size() == 0) begin
                    note_mismatch("result with no transfer pending", 64'd0, 64'(got_mix.mix));
                end else begin
                    want = mix_expect_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got_mix.mix[i] !== want.mix[i]) begin
                            note_mismatch(chan_name[i], 64'(want.mix[i]), 64'(got_mix.mix[i]));
                        end
                    end
                    if (got_mix.eoi !== want.eoi) begin
                        note_mismatch("end_of_image_out", 64'(want.eoi), 64'(got_mix.eoi));
                    end
                end
            end
            if (start && !busy) begin
                mix_expect_q.push_back(predict_mix(cur_mode, cur_factor, drv_pair));
            end
        end
    end

    initial begin
        logic  mode;
        t_chan factor;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_MODE;
        cfg_data     = '0;
        start        = 1'b0;
        drv_pair     = '0;
        pix_taken    = 1'b0;
        cur_mode     = MODE_OVER;
        cur_factor   = t_chan'(Q_ONE);
        send_gap_pct = 0;
        err_count    = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            mode   = MODE_OVER;
            factor = t_chan'(Q_ONE);
            case (ph)
                1: factor = 16'hC000;
                2: factor = 16'h0000;
                3: mode = MODE_UNDER;
                4: begin
                    mode   = MODE_UNDER;
                    factor = 16'hFFFF;
                end
                5: begin
                    mode   = MODE_UNDER;
                    factor = 16'h0000;
                end
                6: begin
                    mode   = MODE_UNDER;
                    factor = t_chan'($urandom_range(32'd1, 32'(Q_ONE - 1)));
                end
                7: factor = t_chan'($urandom_range(32'd1, 32'(Q_ONE - 1)));
                8: factor = t_chan'($urandom_range(32'(Q_ONE + 1), 32'(Q_MAX - 1)));
                default: begin
                end
            endcase
            if (ph != 0) begin
                wait_drained();
                write_cfg(mode, factor);
            end
            case (ph % 3)
                0: send_gap_pct = 0;
                1: send_gap_pct = 53;
                default: send_gap_pct = 26;
            endcase
            push_directed(ph);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                push_pair(rand_pix(), rand_pix(), $urandom_range(15) == 0);
            end
        end

        wait_drained();
        if (err_count == 0) begin
            $display("alpha_over_under_composite_unit_tb: clean");
        end else begin
            $display("alpha_over_under_composite_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== alpha_over_under_composite_unit.f =====
src/aouc_pkg.sv
src/alpha_over_under_composite_unit.sv
tb/sv/alpha_over_under_composite_unit_tb.sv
